### design/lcps_pkg.sv
// Package for the line centroid PD steering block.
// Field widths, register map, reset values and shared types.
// No dependencies; used by every file in design/.
package lcps_pkg;

    localparam int PIXELS_DEF  = 320;

    localparam int SAMPLE_W    = 12;
    localparam int POS_W       = 10;
    localparam int OFFSET_W    = 10;
    localparam int GAIN_W      = 16;
    localparam int SPEED_W     = 16;
    localparam int TURN_W      = 23;
    localparam int ERR_W       = 12;
    localparam int CHG_W       = 13;
    localparam int ACC_W       = GAIN_W + 1 + CHG_W;
    localparam int DIV_W       = ACC_W - 1;
    localparam int DIVISOR_W   = 11;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int STEER_DIV   = 130;

    // x / 130 == (x * RECIP_130) >> RECIP_SH, exact for x below 2^30
    localparam int RECIP_W     = 29;
    localparam int RECIP_SH    = 36;
    localparam logic [RECIP_W-1:0] RECIP_130 = 29'd528611360;
    localparam int SCALE_W     = DIV_W + RECIP_W;

    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 56;
    localparam int TURN_LSB    = POS_W;
    localparam int SPEED_LSB   = TURN_LSB + TURN_W;
    localparam int M_USED_W    = SPEED_LSB + SPEED_W;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIT_THRESHOLD = 3'd0,
        CFG_TARGET_CENTER = 3'd1,
        CFG_CENTER_OFFSET = 3'd2,
        CFG_PROP_GAIN     = 3'd3,
        CFG_DERIV_GAIN    = 3'd4,
        CFG_CRUISE_SPEED  = 3'd5
    } cfg_idx_t;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd41;
    localparam logic [POS_W-1:0]    TARGET_RST    = 10'd144;
    localparam logic [OFFSET_W-1:0] OFFSET_RST    = 10'd0;
    localparam logic [GAIN_W-1:0]   PROP_RST      = 16'd51;
    localparam logic [GAIN_W-1:0]   DERIV_RST     = 16'd26;
    localparam logic [SPEED_W-1:0]  SPEED_RST     = 16'd128;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### design/line_centroid_pd_steering.sv
// Line sensor centroid and PD steering, top level.
// Depends on lcps_pkg and lcps_divider.
//
//  channel | ports                          | carries
//  --------+--------------------------------+-----------------------------------
//  pixel   | s_tvalid s_tready s_tdata s_tlast | sample, frame_end on tlast
//  result  | m_tvalid m_tready m_tdata m_tuser | position, turn, speed; stopped
//  config  | cfg_valid cfg_ready cfg_index cfg_data | register writes, always ready
//
// The frame_end transaction starts a back-end pass: the centroid on the
// bit-serial divider, then error, P and D products on one shared multiplier,
// sum, magnitude, reciprocal multiply for the divide by 130 and sign. With no
// lit pixel the divider is not started; a zero centroid ends the pass after
// the divide. s_tready is low during that pass and while the previous result
// still sits unread in the output register. Reset is synchronous.
module line_centroid_pd_steering
    import lcps_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample, rest zero
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] line_position, [32:10] turn_rate,
                                             // [48:33] drive_speed, rest zero
    output logic                  m_tuser,   // [0] stopped
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(PIXELS + 1);
    localparam int SUM_W = $clog2(PIXELS * (PIXELS - 1) / 2 + 1);

    typedef enum logic [10:0] {
        ST_PIX    = 11'b00000000001,
        ST_CSTART = 11'b00000000010,
        ST_CWAIT  = 11'b00000000100,
        ST_ERR    = 11'b00000001000,
        ST_MULP   = 11'b00000010000,
        ST_MULD   = 11'b00000100000,
        ST_SUM    = 11'b00001000000,
        ST_ABS    = 11'b00010000000,
        ST_SCALE  = 11'b00100000000,
        ST_SIGN   = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] thr_reg;
    logic [POS_W-1:0]    target_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [GAIN_W-1:0]   prop_reg;
    logic [GAIN_W-1:0]   deriv_reg;
    logic [SPEED_W-1:0]  speed_reg;

    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [IDX_W-1:0]    fcnt_reg;
    logic [SUM_W-1:0]    fsum_reg;
    logic signed [CHG_W-1:0] prev_reg;

    logic [POS_W-1:0]        centroid_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [CHG_W-1:0] chg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic                    neg_reg;
    logic signed [TURN_W-1:0] turn_reg;
    logic                    stop_reg;

    logic                m_valid_reg;
    logic [POS_W-1:0]    pos_out_reg;
    logic [TURN_W-1:0]   turn_out_reg;
    logic [SPEED_W-1:0]  speed_out_reg;
    logic                stop_out_reg;

    logic                pix_acc;
    logic                in_range;
    logic                lit;
    logic [IDX_W-1:0]    cnt_upd;
    logic [SUM_W-1:0]    sum_upd;

    logic signed [GAIN_W:0]  mul_a;
    logic signed [CHG_W-1:0] mul_b;
    logic signed [ACC_W-1:0] mul_p;
    logic signed [ACC_W-1:0] acc_mag;
    logic signed [ERR_W-1:0] err_calc;
    logic [SCALE_W-1:0]      scale_p;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [DIV_W-1:0]     div_quotient;
    div_stat_t            div_stat;
    logic                 out_free;

    assign s_tready  = state_reg == ST_PIX;
    assign cfg_ready = 1'b1;
    assign pix_acc   = s_tvalid && s_tready;
    assign in_range  = idx_reg < IDX_W'(PIXELS);
    assign lit       = in_range && (s_tdata[SAMPLE_W-1:0] > thr_reg);
    assign cnt_upd   = lit ? cnt_reg + 1'b1 : cnt_reg;
    assign sum_upd   = lit ? sum_reg + SUM_W'(idx_reg) : sum_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // shared multiplier: P term, then D term
    assign mul_a = (state_reg == ST_MULP) ? $signed({1'b0, prop_reg})
                                          : $signed({1'b0, deriv_reg});
    assign mul_b = (state_reg == ST_MULP) ? CHG_W'(err_reg) : chg_reg;
    assign mul_p = mul_a * mul_b;

    assign acc_mag  = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign err_calc = $signed({2'b00, target_reg}) - $signed({2'b00, centroid_reg})
                      + ERR_W'(signed'(offset_reg));
    assign scale_p  = SCALE_W'(prod_reg[DIV_W-1:0]) * SCALE_W'(RECIP_130);

    assign div_start    = (state_reg == ST_CSTART) && (fcnt_reg != '0);
    assign div_dividend = DIV_W'(fsum_reg);
    assign div_divisor  = DIVISOR_W'(fcnt_reg);

    lcps_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_PIX:    if (pix_acc && s_tlast) state_next = ST_CSTART;
            ST_CSTART: state_next = (fcnt_reg == '0) ? ST_DONE : ST_CWAIT;
            ST_CWAIT: begin
                if (div_stat.done) begin
                    state_next = (div_quotient == '0) ? ST_DONE : ST_ERR;
                end
            end
            ST_ERR:    state_next = ST_MULP;
            ST_MULP:   state_next = ST_MULD;
            ST_MULD:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_ABS;
            ST_ABS:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_SIGN;
            ST_SIGN:   state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_PIX;
            default:   state_next = ST_PIX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_PIX;
            thr_reg     <= THRESHOLD_RST;
            target_reg  <= TARGET_RST;
            offset_reg  <= OFFSET_RST;
            prop_reg    <= PROP_RST;
            deriv_reg   <= DERIV_RST;
            speed_reg   <= SPEED_RST;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LIT_THRESHOLD: thr_reg    <= cfg_data[SAMPLE_W-1:0];
                    CFG_TARGET_CENTER: target_reg <= cfg_data[POS_W-1:0];
                    CFG_CENTER_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                    CFG_PROP_GAIN:     prop_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:    deriv_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_CRUISE_SPEED:  speed_reg  <= cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (pix_acc) begin
                if (s_tlast) begin
                    idx_reg <= '0;
                    cnt_reg <= '0;
                    sum_reg <= '0;
                end else begin
                    cnt_reg <= cnt_upd;
                    sum_reg <= sum_upd;
                    if (in_range) idx_reg <= idx_reg + 1'b1;
                end
            end
            if (state_reg == ST_SUM) prev_reg <= CHG_W'(err_reg);
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc && s_tlast) begin
            fcnt_reg <= cnt_upd;
            fsum_reg <= sum_upd;
        end
        case (state_reg)
            ST_CSTART: begin
                centroid_reg <= '0;
                stop_reg     <= 1'b1;
            end
            ST_CWAIT: begin
                centroid_reg <= div_quotient[POS_W-1:0];
                stop_reg     <= div_quotient == '0;
            end
            ST_ERR:  err_reg <= err_calc;
            ST_MULP: begin
                acc_reg <= mul_p;
                chg_reg <= CHG_W'(err_reg) - prev_reg;
            end
            ST_MULD: prod_reg <= mul_p;
            ST_SUM:  acc_reg  <= acc_reg + prod_reg;
            ST_ABS: begin
                neg_reg  <= acc_reg[ACC_W-1];
                prod_reg <= acc_mag;
            end
            ST_SCALE: turn_reg <= signed'({1'b0, scale_p[RECIP_SH +: TURN_W-1]});
            ST_SIGN:  turn_reg <= neg_reg ? -turn_reg : turn_reg;
            ST_DONE: begin
                if (out_free) begin
                    pos_out_reg   <= centroid_reg;
                    turn_out_reg  <= stop_reg ? '0 : turn_reg;
                    speed_out_reg <= stop_reg ? '0 : speed_reg;
                    stop_out_reg  <= stop_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, speed_out_reg, turn_out_reg,
                       pos_out_reg};
    assign m_tuser  = stop_out_reg;

endmodule

### design/lcps_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Used for the centroid division.
// Depends on lcps_pkg.
module lcps_divider
    import lcps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [DIV_W-1:0]     quotient,
    output div_stat_t            status
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] dsr_reg;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;
    logic                 last_step;

    assign shifted   = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = shifted >= {1'b0, dsr_reg};
    assign diff      = shifted - {1'b0, dsr_reg};
    assign last_step = cnt_reg == DIV_CNT_W'(DIV_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### design/lcps_checker.sv
// Port-level checker for line_centroid_pd_steering, attached by bind.
// Depends on lcps_pkg.
module lcps_checker
    import lcps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[M_USED_W-1:0] == '0)
        else $error("stopped result carries nonzero fields");

    a_run_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[POS_W-1:0] != '0)
        else $error("running result with zero line position");

    a_busy_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("pixel taken right after frame end");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind line_centroid_pd_steering lcps_checker u_lcps_checker (.*);
